/* hdl/qta_pkg.sv */
// Package for the quadtree atlas allocator: request/response types,
// command codes and level-size helper. No dependencies.
package qta_pkg;

  localparam int unsigned DEF_ROOT_WIDTH_LOG2  = 8;
  localparam int unsigned DEF_ROOT_HEIGHT_LOG2 = 8;
  localparam int unsigned DEF_TREE_LEVELS      = 6;
  localparam int unsigned LEVEL_SIZE_W         = 13;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [8:0] req_width;
    logic [8:0] req_height;
    logic [7:0] req_x;
    logic [7:0] req_y;
  } qta_req_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] blk_x;
    logic [7:0] blk_y;
    logic [8:0] blk_width;
    logic [8:0] blk_height;
  } qta_rsp_t;

  // Side length of a block at depth d; zero below one pixel.
  function automatic logic [LEVEL_SIZE_W-1:0] level_size(int unsigned lg, int unsigned d);
    logic [LEVEL_SIZE_W-1:0] r;
    r = '0;
    if (d <= lg) r[lg-d] = 1'b1;
    return r;
  endfunction

endpackage

/* hdl/qta_stream_if.sv */
// Valid/ready stream interface carrying one payload per transaction.
// Payload type is a parameter; used with qta_pkg types.
interface qta_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/qta_node_store.sv */
// Node store: single write port, single read port, registered read data.
// No package dependency.
module qta_node_store #(
  parameter int unsigned DEPTH = 5461,
  parameter int unsigned AW    = 13,
  parameter int unsigned DW    = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

/* hdl/quadtree_atlas_allocator_unit.sv */
// Quadtree atlas allocator top level over the node store (qta_pkg, qta_stream_if, qta_node_store).
// Alloc: at each level the node is read and, while the child level can hold the request, its
//   four children are scanned and the search descends into the best fit; the node found is marked
//   taken and its ancestors refreshed. Free walks down, reads and clears the node, refreshes ancestors.
// Throughput: one request at a time; the next is taken the cycle after the response registers.
// Reset: the store is swept one node per cycle, all NODE_COUNT nodes (5461 at defaults), first.
module quadtree_atlas_allocator_unit
  import qta_pkg::*;
#(
  parameter int unsigned ROOT_WIDTH_LOG2  = DEF_ROOT_WIDTH_LOG2,
  parameter int unsigned ROOT_HEIGHT_LOG2 = DEF_ROOT_HEIGHT_LOG2,
  parameter int unsigned TREE_LEVELS      = DEF_TREE_LEVELS
) (
  input  logic clk_i,
  input  logic rst_ni,
  qta_stream_if.sink   req_i,
  qta_stream_if.source rsp_o
);
  localparam int unsigned NODE_COUNT = ((1 << (2 * (TREE_LEVELS + 1))) - 1) / 3;
  localparam int unsigned NW  = $clog2(NODE_COUNT);
  localparam int unsigned DPW = $clog2(TREE_LEVELS + 2);
  localparam int unsigned LGM = (ROOT_WIDTH_LOG2 > ROOT_HEIGHT_LOG2) ?
                                ROOT_WIDTH_LOG2 : ROOT_HEIGHT_LOG2;
  localparam int unsigned SW  = (LGM + 1 > 9) ? LGM + 1 : 9;  // size / coordinate width
  localparam int unsigned CW  = SW + 1;                       // containment compare width
  localparam int unsigned EW  = 1 + NW + 2 * SW;              // store entry width

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_A_RD, S_A_NODE, S_A_CH, S_A_DEC,
    S_F_WALK, S_F_RD, S_F_NODE, S_U_RD, S_U_FIN, S_DONE
  } state_e;

  state_e          state_q;
  logic [NW-1:0]   node_q, clr_end_q;
  logic [DPW-1:0]  depth_q, clr_lvl_q;
  logic [SW-1:0]   px_q, py_q, bw_q, bh_q, maxw_q, maxh_q;
  logic [2:0]      k_q;
  logic            best_vld_q, ptaken_q, up_q, out_vld_q;
  logic [1:0]      best_q;
  logic [NW-1:0]   busy_q;
  logic [8:0]      mw_q, mh_q;
  logic [7:0]      rx_q, ry_q;
  logic [9:0]      ex_q, ey_q;
  qta_rsp_t        res_q, out_q;

  // store port
  logic            mem_we;
  logic [NW-1:0]   mem_waddr, mem_raddr;
  logic [EW-1:0]   mem_wdata, mem_rdata;

  qta_node_store #(.DEPTH(NODE_COUNT), .AW(NW), .DW(EW)) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  logic          rd_taken;
  logic [NW-1:0] rd_busy;
  logic [SW-1:0] rd_fw, rd_fh;
  assign rd_taken = mem_rdata[EW-1];
  assign rd_busy  = mem_rdata[EW-2 -: NW];
  assign rd_fw    = mem_rdata[2*SW-1 -: SW];
  assign rd_fh    = mem_rdata[SW-1:0];

  // level sizes at the current depth, one below, and at the sweep level
  logic [LEVEL_SIZE_W-1:0] lw_cur, lh_cur, lw_nxt, lh_nxt, lw_clr, lh_clr;
  logic [SW-1:0] nw, nh, cw, ch;
  assign lw_cur = level_size(ROOT_WIDTH_LOG2,  int'(depth_q));
  assign lh_cur = level_size(ROOT_HEIGHT_LOG2, int'(depth_q));
  assign lw_nxt = level_size(ROOT_WIDTH_LOG2,  int'(depth_q) + 1);
  assign lh_nxt = level_size(ROOT_HEIGHT_LOG2, int'(depth_q) + 1);
  assign lw_clr = level_size(ROOT_WIDTH_LOG2,  int'(clr_lvl_q));
  assign lh_clr = level_size(ROOT_HEIGHT_LOG2, int'(clr_lvl_q));
  assign nw = SW'(lw_nxt);
  assign nh = SW'(lh_nxt);
  assign cw = SW'(lw_cur);
  assign ch = SW'(lh_cur);

  logic [NW-1:0] cbase, pnode, pbase;
  assign cbase = NW'({node_q, 2'b01});
  assign pnode = NW'((node_q - NW'(1)) >> 2);
  assign pbase = NW'({pnode, 2'b01});

  logic deeper, scan, fits, better;
  assign deeper = 32'(depth_q) < TREE_LEVELS;
  assign scan   = deeper && (CW'(nw) >= CW'(mw_q)) && (CW'(nh) >= CW'(mh_q));
  assign fits   = (CW'(rd_fw) >= CW'(mw_q)) && (CW'(rd_fh) >= CW'(mh_q));
  assign better = !best_vld_q || ((rd_fw < bw_q) && (rd_fh < bh_q));

  // containment of the free rectangle in each child, first match wins
  logic [3:0]    hit;
  logic [SW-1:0] cx [4];
  logic [SW-1:0] cy [4];
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      cx[c]  = px_q + (c[0] ? nw : '0);
      cy[c]  = py_q + (c[1] ? nh : '0);
      hit[c] = (CW'(rx_q) >= CW'(cx[c])) && (CW'(ry_q) >= CW'(cy[c])) &&
               (CW'(ex_q) <= CW'(cx[c]) + CW'(nw)) &&
               (CW'(ey_q) <= CW'(cy[c]) + CW'(nh));
    end
  end
  logic [1:0] hit_idx;
  always_comb begin
    case (1'b1)
      hit[0]:  hit_idx = 2'd0;
      hit[1]:  hit_idx = 2'd1;
      hit[2]:  hit_idx = 2'd2;
      default: hit_idx = 2'd3;
    endcase
  end

  logic [SW-1:0] fin_w, fin_h;
  assign fin_w = (rd_fw > maxw_q) ? rd_fw : maxw_q;
  assign fin_h = (rd_fh > maxh_q) ? rd_fh : maxh_q;

  // store control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = node_q;
    mem_wdata = '0;
    mem_raddr = node_q;
    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = {1'b0, {NW{1'b0}}, SW'(lw_clr), SW'(lh_clr)};
      end
      S_A_NODE: mem_raddr = cbase;
      S_A_CH:   mem_raddr = cbase + NW'(k_q) + NW'(1);
      S_A_DEC: begin
        mem_we    = !best_vld_q && (busy_q == '0);
        mem_wdata = {1'b1, busy_q, {SW{1'b0}}, {SW{1'b0}}};
      end
      S_F_NODE: begin
        mem_we    = rd_taken;
        mem_wdata = {1'b0, rd_busy, cw, ch};
      end
      S_U_RD:   mem_raddr = (k_q == 3'd0) ? pnode : pbase + NW'(k_q) - NW'(1);
      S_U_FIN: begin
        mem_we    = 1'b1;
        mem_waddr = pnode;
        mem_wdata = {ptaken_q, up_q ? busy_q + NW'(1) : busy_q - NW'(1), fin_w, fin_h};
      end
      default: ;
    endcase
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = out_vld_q;
  assign rsp_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      node_q     <= '0;
      clr_lvl_q  <= '0;
      clr_end_q  <= '0;
      depth_q    <= '0;
      k_q        <= '0;
      best_vld_q <= 1'b0;
      up_q       <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (out_vld_q && rsp_o.ready) out_vld_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          if (32'(node_q) == NODE_COUNT - 1) begin
            state_q <= S_IDLE;
          end else begin
            node_q <= node_q + NW'(1);
            if (node_q == clr_end_q) begin
              clr_lvl_q <= clr_lvl_q + DPW'(1);
              clr_end_q <= NW'({clr_end_q, 2'b00} + 4);
            end
          end
        end
        S_IDLE: begin
          if (req_i.valid) begin
            mw_q    <= req_i.data.req_width;
            mh_q    <= req_i.data.req_height;
            rx_q    <= req_i.data.req_x;
            ry_q    <= req_i.data.req_y;
            ex_q    <= 10'(req_i.data.req_x) + 10'(req_i.data.req_width);
            ey_q    <= 10'(req_i.data.req_y) + 10'(req_i.data.req_height);
            res_q   <= '0;
            node_q  <= '0;
            depth_q <= '0;
            px_q    <= '0;
            py_q    <= '0;
            if (req_i.data.cmd == CMD_FREE) begin
              state_q <= S_F_WALK;
            end else if (req_i.data.req_width == '0 || req_i.data.req_height == '0) begin
              state_q <= S_DONE;
            end else begin
              state_q <= S_A_RD;
            end
          end
        end
        S_A_RD: state_q <= S_A_NODE;
        S_A_NODE: begin
          busy_q     <= rd_busy;
          best_vld_q <= 1'b0;
          k_q        <= '0;
          if (rd_taken) state_q <= S_DONE;
          else if (scan) state_q <= S_A_CH;
          else state_q <= S_A_DEC;
        end
        S_A_CH: begin
          if (fits && better) begin
            best_vld_q <= 1'b1;
            best_q     <= k_q[1:0];
            bw_q       <= rd_fw;
            bh_q       <= rd_fh;
          end
          k_q <= k_q + 3'd1;
          if (k_q == 3'd3) state_q <= S_A_DEC;
        end
        S_A_DEC: begin
          if (!best_vld_q) begin
            if (busy_q != '0) begin
              state_q <= S_DONE;
            end else begin
              res_q <= '{ok: 1'b1, blk_x: px_q[7:0], blk_y: py_q[7:0],
                         blk_width: lw_cur[8:0], blk_height: lh_cur[8:0]};
              up_q    <= 1'b1;
              k_q     <= '0;
              state_q <= (node_q == '0) ? S_DONE : S_U_RD;
            end
          end else begin
            if (best_q[0]) px_q <= px_q + nw;
            if (best_q[1]) py_q <= py_q + nh;
            node_q  <= cbase + NW'(best_q);
            depth_q <= depth_q + DPW'(1);
            state_q <= S_A_RD;
          end
        end
        S_F_WALK: begin
          if (deeper && (hit != 4'b0000)) begin
            px_q    <= cx[hit_idx];
            py_q    <= cy[hit_idx];
            node_q  <= cbase + NW'(hit_idx);
            depth_q <= depth_q + DPW'(1);
          end else begin
            state_q <= S_F_RD;
          end
        end
        S_F_RD: state_q <= S_F_NODE;
        S_F_NODE: begin
          if (!rd_taken) begin
            state_q <= S_DONE;
          end else begin
            res_q.ok <= 1'b1;
            up_q     <= 1'b0;
            k_q      <= '0;
            state_q  <= (node_q == '0) ? S_DONE : S_U_RD;
          end
        end
        S_U_RD: begin
          if (k_q == 3'd1) begin
            ptaken_q <= rd_taken;
            busy_q   <= rd_busy;
          end
          if (k_q == 3'd2) begin
            maxw_q <= rd_fw;
            maxh_q <= rd_fh;
          end else if (k_q > 3'd2) begin
            maxw_q <= fin_w;
            maxh_q <= fin_h;
          end
          k_q <= k_q + 3'd1;
          if (k_q == 3'd4) state_q <= S_U_FIN;
        end
        S_U_FIN: begin
          node_q  <= pnode;
          k_q     <= '0;
          state_q <= (pnode == '0) ? S_DONE : S_U_RD;
        end
        S_DONE: begin
          if (!out_vld_q || rsp_o.ready) begin
            out_q     <= res_q;
            out_vld_q <= 1'b1;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // no request is taken while the reset sweep runs
  a_no_req_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !req_i.ready)
    else $error("request accepted during store sweep");
  // a failed allocation reports an all-zero block
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.ok) |-> (out_q.blk_width == '0 && out_q.blk_height == '0))
    else $error("failed result carries a block size");
  // store writes stay inside the tree
  a_waddr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (32'(mem_waddr) < NODE_COUNT))
    else $error("store write out of range");
  // the sweep ends exactly once and never resumes
  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_CLEAR) |=> (state_q != S_CLEAR))
    else $error("store sweep restarted");
`endif

endmodule
